### rtl/core/bpe_pkg.sv
// Package for the bicubic patch evaluator: widths, codes, payload and control types.
// No dependencies; the multiply-accumulate unit, the sequencer, the top level and the checker import it.
package bpe_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int DEF_MAX_CELLS_X = 16;
    localparam int DEF_MAX_CELLS_Y = 16;
    localparam int DEF_ORDER       = 4;

    // Fixed field widths
    localparam int VAL_W     = 32;   // Q16.16 values
    localparam int FRAC_W    = 16;
    localparam int PT_W      = 24;   // Q8.16 coordinates
    localparam int ADDR_IN_W = 12;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_W    = 4;    // 16 coefficient slots per cell
    localparam int CELL_W    = 7;    // cell counts and indexes up to 127
    localparam int DX_W      = 26;   // offset from the clamped cell, Q10.16
    localparam int PROD_W    = VAL_W + DX_W;
    localparam int SUM_W     = PROD_W - FRAC_W + 1;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 1'b1;

    localparam logic [CFG_W-1:0] CELLS_RESET = 5'd16;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                          command;
        logic [ADDR_IN_W-1:0]          coeff_address;
        logic signed [VAL_W-1:0]       coeff_value;
        logic signed [PT_W-1:0]        point_x;
        logic signed [PT_W-1:0]        point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]       interp_value;
        logic                          saturated;
    } t_out_item;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;    // clear the saturation flag
        logic load;   // load the accumulator from the addend
        logic mul;    // register accumulator times operand
        logic add;    // accumulator = sat(floor(product) + addend)
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIRST,
        ST_MUL,
        ST_ADD,
        ST_OMUL,
        ST_OADD,
        ST_DONE
    } t_state;

endpackage

### rtl/core/bpe_stream_if.sv
// Valid/ready stream channel used for the item and result ports.
// Payload type is a parameter; payload structs come from bpe_pkg.
interface bpe_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport mon    (input valid, input data, input ready);
endinterface

### rtl/core/bpe_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/bpe_mac.sv
// Shared multiply-accumulate unit: registered product, then floor, add and saturate.
// Depends on bpe_pkg.
module bpe_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpe_pkg::t_mac_ctl                i_ctl,
    input  logic signed [bpe_pkg::DX_W-1:0]  i_mul_op,
    input  logic signed [bpe_pkg::VAL_W-1:0] i_add_op,
    output logic signed [bpe_pkg::VAL_W-1:0] o_acc,
    output logic signed [bpe_pkg::VAL_W-1:0] o_acc_next,
    output logic                             o_sat
);
    import bpe_pkg::*;

    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [VAL_W-1:0]  r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic signed [SUM_W-2:0]  prod_hi;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic signed [VAL_W-1:0]  sat_val;

    // Floor the product by dropping the fraction, add, and clip to 32 bits
    always_comb begin
        prod_hi = r_prod[PROD_W-1:FRAC_W];
        sum     = SUM_W'(prod_hi) + SUM_W'(i_add_op);
        ovf     = (sum[SUM_W-1:VAL_W-1] != '0) && (sum[SUM_W-1:VAL_W-1] != '1);
        if (ovf) begin
            sat_val = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
        end else begin
            sat_val = sum[VAL_W-1:0];
        end
    end

    always_comb begin
        n_prod = r_prod;
        n_acc  = r_acc;
        n_sat  = r_sat;
        if (i_ctl.mul) begin
            n_prod = PROD_W'(r_acc) * PROD_W'(i_mul_op);
        end
        if (i_ctl.load) begin
            n_acc = i_add_op;
        end else if (i_ctl.add) begin
            n_acc = sat_val;
        end
        if (i_ctl.clr) begin
            n_sat = 1'b0;
        end else if (i_ctl.add && ovf) begin
            n_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else begin
            r_sat <= n_sat;
        end
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_acc      = r_acc;
    assign o_acc_next = n_acc;
    assign o_sat      = r_sat;
endmodule

### rtl/core/bpe_seq.sv
// Sequencer: configuration registers, cell setup, coefficient addressing,
// Horner step control, row sums and the result register. Depends on bpe_pkg.
module bpe_seq #(
    parameter int MAX_CELLS_X = bpe_pkg::DEF_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = bpe_pkg::DEF_MAX_CELLS_Y,
    parameter int ORDER       = bpe_pkg::DEF_ORDER,
    parameter int AW          = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]            i_cfg_data,
    bpe_stream_if.sink                           i_in,
    bpe_stream_if.source                         o_res,
    output logic                                 o_ram_we,
    output logic [AW-1:0]                        o_ram_addr,
    output logic [bpe_pkg::VAL_W-1:0]            o_ram_wdata,
    input  logic signed [bpe_pkg::VAL_W-1:0]     i_ram_rdata,
    output bpe_pkg::t_mac_ctl                    o_mac_ctl,
    output logic signed [bpe_pkg::DX_W-1:0]      o_mul_op,
    output logic signed [bpe_pkg::VAL_W-1:0]     o_add_op,
    input  logic signed [bpe_pkg::VAL_W-1:0]     i_acc,
    input  logic signed [bpe_pkg::VAL_W-1:0]     i_acc_next,
    input  logic                                 i_sat
);
    import bpe_pkg::*;

    localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y * (1 << SLOT_W);
    localparam int ORD_W = $clog2(ORDER);

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_cells_x, r_cells_y;
    logic [ORD_W-1:0]         r_ox, n_ox, r_oy, n_oy;
    logic signed [DX_W-1:0]   r_dx, n_dx, r_dy, n_dy;
    logic [AW-1:0]            r_base, n_base;
    logic signed [VAL_W-1:0]  r_rows [ORDER];
    logic                     row_we;
    logic                     r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic                     r_out_sat, n_out_sat;
    logic                     accept;
    logic [CELL_W-1:0]        nx, ny, cx, cy;
    logic [AW-1:0]            cell_lin;

    // Count register held to 1..max
    function automatic logic [CELL_W-1:0] clamp_count(input logic [CFG_W-1:0] raw,
                                                      input int maxv);
        logic [CELL_W-1:0] v;
        v = CELL_W'(raw);
        if (v == '0) begin
            v = CELL_W'(1);
        end else if (v > CELL_W'(maxv)) begin
            v = CELL_W'(maxv);
        end
        return v;
    endfunction

    // Floored coordinate held to 0..n-1
    function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [PT_W-FRAC_W-1:0] f,
                                                     input logic [CELL_W-1:0] n);
        logic [CELL_W-1:0] v;
        if (f[PT_W-FRAC_W-1]) begin
            v = '0;
        end else if (CELL_W'(f) > n - CELL_W'(1)) begin
            v = n - CELL_W'(1);
        end else begin
            v = CELL_W'(f);
        end
        return v;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CELLS_RESET;
            r_cells_y <= CELLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELLS_X: r_cells_x <= i_cfg_data;
                CFG_CELLS_Y: r_cells_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cell selection and offsets from the incoming point
    always_comb begin
        nx       = clamp_count(r_cells_x, MAX_CELLS_X);
        ny       = clamp_count(r_cells_y, MAX_CELLS_Y);
        cx       = clamp_cell(i_in.data.point_x[PT_W-1:FRAC_W], nx);
        cy       = clamp_cell(i_in.data.point_y[PT_W-1:FRAC_W], ny);
        cell_lin = AW'(AW'(cx) * AW'(ny)) + AW'(cy);
    end

    // Take items only when idle and out of reset
    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_ram_wdata = i_in.data.coeff_value;

    // Next state, step control and address generation
    always_comb begin
        n_state     = r_state;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_base      = r_base;
        row_we      = 1'b0;
        o_mac_ctl   = '0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_base + AW'({r_ox, 2'b00}) + AW'(r_oy);
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.data.command == CMD_WRITE) begin
                        o_ram_addr = AW'(i_in.data.coeff_address);
                        o_ram_we   = (32'(i_in.data.coeff_address) < DEPTH);
                    end else begin
                        n_dx = DX_W'(i_in.data.point_x) -
                               $signed(DX_W'({cx, FRAC_W'(0)}));
                        n_dy = DX_W'(i_in.data.point_y) -
                               $signed(DX_W'({cy, FRAC_W'(0)}));
                        n_base        = cell_lin << SLOT_W;
                        n_ox          = '0;
                        n_oy          = ORD_W'(ORDER - 1);
                        o_mac_ctl.clr = 1'b1;
                        n_state       = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_state = ST_FIRST;
            end
            ST_FIRST: begin
                o_mac_ctl.load = 1'b1;
                n_oy           = r_oy - ORD_W'(1);
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_mac_ctl.mul = 1'b1;
                n_state       = ST_ADD;
            end
            ST_ADD: begin
                o_mac_ctl.add = 1'b1;
                if (r_oy == '0) begin
                    row_we = 1'b1;
                    if (r_ox == ORD_W'(ORDER - 1)) begin
                        n_ox    = ORD_W'(ORDER - 2);
                        n_state = ST_OMUL;
                    end else begin
                        n_ox    = r_ox + ORD_W'(1);
                        n_oy    = ORD_W'(ORDER - 1);
                        n_state = ST_LOAD;
                    end
                end else begin
                    n_oy    = r_oy - ORD_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_OMUL: begin
                o_mac_ctl.mul = 1'b1;
                n_state       = ST_OADD;
            end
            ST_OADD: begin
                o_mac_ctl.add = 1'b1;
                if (r_ox == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_ox    = r_ox - ORD_W'(1);
                    n_state = ST_OMUL;
                end
            end
            ST_DONE: begin
                // Hold until the result register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = i_acc;
                    n_out_sat   = i_sat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Operands for the shared unit: dx only in the outer pass
    assign o_mul_op = (r_state == ST_OMUL) ? r_dx : r_dy;
    assign o_add_op = (r_state == ST_OADD) ? r_rows[r_ox] : i_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_base      <= n_base;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
        if (row_we) begin
            r_rows[r_ox] <= i_acc_next;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.data.interp_value = r_out_value;
    assign o_res.data.saturated    = r_out_sat;
endmodule

### rtl/core/bicubic_patch_evaluator.sv
// Bicubic patch evaluator: holds ORDER x ORDER polynomial coefficients per grid
// cell and evaluates the patch at a point. A coefficient write gives no result
// and leaves the block ready for the next item. An evaluation keeps the block
// busy until its result is registered: every coefficient is read in turn from
// the single-port store, and each Horner step passes through the shared
// multiplier and then the add/saturate stage. The result waits in an output
// register, so the next item may be taken while it is still pending; an
// evaluation that finishes while that register is still full holds in its last
// cycle until the pending result is transferred. Values are Q16.16 with
// products floored; any clipping during the evaluation raises the saturated
// flag. The store has no reset: coefficients of a cell must be written before
// that cell is evaluated.
// Depends on bpe_pkg, bpe_stream_if, bpe_ram, bpe_mac and bpe_seq.
module bicubic_patch_evaluator #(
    parameter int MAX_CELLS_X = bpe_pkg::DEF_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = bpe_pkg::DEF_MAX_CELLS_Y,
    parameter int ORDER       = bpe_pkg::DEF_ORDER
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]     i_cfg_data,
    bpe_stream_if.sink                    i_in,
    bpe_stream_if.source                  o_res
);
    import bpe_pkg::*;

    localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y * (1 << SLOT_W);
    localparam int AW    = $clog2(DEPTH);

    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [VAL_W-1:0]        ram_rdata;
    t_mac_ctl                mac_ctl;
    logic signed [DX_W-1:0]  mul_op;
    logic signed [VAL_W-1:0] add_op;
    logic signed [VAL_W-1:0] acc;
    logic signed [VAL_W-1:0] acc_next;
    logic                    sat;

    // Coefficient store
    bpe_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer
    bpe_seq #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y),
        .ORDER       (ORDER),
        .AW          (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_res       (o_res),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata ($signed(ram_rdata)),
        .o_mac_ctl   (mac_ctl),
        .o_mul_op    (mul_op),
        .o_add_op    (add_op),
        .i_acc       (acc),
        .i_acc_next  (acc_next),
        .i_sat       (sat)
    );

    // Shared multiply-accumulate
    bpe_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_mul_op   (mul_op),
        .i_add_op   (add_op),
        .o_acc      (acc),
        .o_acc_next (acc_next),
        .o_sat      (sat)
    );
endmodule

### rtl/core/bpe_checker.sv
// Port-level checks for the bicubic patch evaluator, bound to the top level.
// Depends on bpe_pkg.
module bpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_command,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input bpe_pkg::t_out_item i_res_data
);
    import bpe_pkg::*;

    // A pending result holds its value until transferred
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("result changed or dropped while stalled");

    // An evaluation occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == CMD_EVAL) |=> !i_in_ready)
        else $error("item taken right after an evaluation");

    // A coefficient write finishes in its own cycle
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == CMD_WRITE) |=> i_in_ready)
        else $error("block busy after a coefficient write");

    // A new result only appears at the end of an evaluation
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_in_ready))
        else $error("result appeared without an evaluation in progress");
endmodule

bind bicubic_patch_evaluator bpe_checker u_bpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.data.command),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_data   (o_res.data)
);
